/* src/ttpa_pkg.sv */
// Shared types, widths and codes for the tick/tock phase adjust timer.
package ttpa_pkg;

  localparam int PERIOD_W    = 20;
  localparam int PHASE_REQ_W = 21;
  localparam int PHASE_W     = 19;
  localparam int OFFSET_W    = 16;
  localparam int FUNC_W      = 3;
  localparam int EVENT_W     = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;
  localparam int SUM_W       = 22;

  localparam logic [FUNC_W-1:0] FN_TIME      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_START     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_STOP      = 3'd2;
  localparam logic [FUNC_W-1:0] FN_OFF_RESET = 3'd3;
  localparam logic [FUNC_W-1:0] FN_OFF_INC   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_OFF_DEC   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SET_PHASE = 3'd6;

  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_TICK = 2'd1;
  localparam logic [EVENT_W-1:0] EV_TOCK = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd4000;

  localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = 16'sh7FFF;
  localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = 16'sh8000;

  typedef struct packed {
    logic [FUNC_W-1:0]             func;
    logic signed [PHASE_REQ_W-1:0] phase_request;
  } item_t;

  typedef struct packed {
    logic [EVENT_W-1:0]         event_res;
    logic signed [OFFSET_W-1:0] offset_now;
  } result_t;

endpackage

/* src/ttpa_in_stage.sv */
// Input register stage for command transactions.
module ttpa_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ttpa_pkg::item_t in_item,
  input  logic          take,
  output logic          item_valid,
  output ttpa_pkg::item_t item
);
  import ttpa_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

/* src/ttpa_core.sv */
// Timer state, reload arithmetic, offset and phase handling.
module ttpa_core #(
  parameter int COUNT_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ttpa_pkg::PERIOD_W-1:0]   cfg_wr_data,
  input  logic                            fire,
  input  ttpa_pkg::item_t                 item,
  output ttpa_pkg::result_t               result
);
  import ttpa_pkg::*;

  localparam int EXT_W = ((COUNT_BITS > SUM_W) ? COUNT_BITS : SUM_W) + 1;
  localparam logic signed [EXT_W-1:0] CMAX_EXT =
    {{(EXT_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
  localparam logic signed [EXT_W-1:0] ONE_EXT = {{(EXT_W-1){1'b0}}, 1'b1};

  logic [PERIOD_W-1:0]         period_r;
  logic                        running_r, running_nxt;
  logic                        next_tick_r, next_tick_nxt;
  logic [COUNT_BITS-1:0]       countdown_r, countdown_nxt;
  logic signed [PHASE_W-1:0]   phase_r, phase_nxt;
  logic signed [OFFSET_W-1:0]  offset_r, offset_nxt;
  logic [EVENT_W-1:0]          ev;

  logic signed [SUM_W-1:0]     half_s, quarter_s, off_s, ph_s, req_s;
  logic signed [SUM_W-1:0]     sum_tick, sum_tock, reload_sum, clamp_s;
  logic signed [EXT_W-1:0]     reload_ext;
  logic [COUNT_BITS-1:0]       reload_val;
  logic [COUNT_BITS-1:0]       cd_dec;

  assign half_s    = $signed({2'b00, 1'b0, period_r[PERIOD_W-1:1]});
  assign quarter_s = $signed({4'b0000, period_r[PERIOD_W-1:2]});
  assign off_s     = {{(SUM_W-OFFSET_W){offset_r[OFFSET_W-1]}}, offset_r};
  assign ph_s      = {{(SUM_W-PHASE_W){phase_r[PHASE_W-1]}}, phase_r};
  assign req_s     = {{(SUM_W-PHASE_REQ_W){item.phase_request[PHASE_REQ_W-1]}},
                      item.phase_request};
  assign sum_tick  = half_s + off_s;
  assign sum_tock  = sum_tick + ph_s;

  always_comb begin
    if (!running_r) begin
      reload_sum = half_s;
    end else if (next_tick_r) begin
      reload_sum = sum_tick;
    end else begin
      reload_sum = sum_tock;
    end
    reload_ext = {{(EXT_W-SUM_W){reload_sum[SUM_W-1]}}, reload_sum};
    if (reload_ext < ONE_EXT) begin
      reload_val = {{(COUNT_BITS-1){1'b0}}, 1'b1};
    end else if (reload_ext > CMAX_EXT) begin
      reload_val = {COUNT_BITS{1'b1}};
    end else begin
      reload_val = reload_ext[COUNT_BITS-1:0];
    end
  end

  always_comb begin
    if (req_s > quarter_s) begin
      clamp_s = quarter_s;
    end else if (req_s < -quarter_s) begin
      clamp_s = -quarter_s;
    end else begin
      clamp_s = req_s;
    end
  end

  assign cd_dec = (countdown_r != '0) ? countdown_r - 1'b1 : countdown_r;

  always_comb begin
    running_nxt   = running_r;
    next_tick_nxt = next_tick_r;
    countdown_nxt = countdown_r;
    phase_nxt     = phase_r;
    offset_nxt    = offset_r;
    ev            = EV_NONE;
    if (fire) begin
      unique case (item.func)
        FN_TIME: begin
          if (running_r) begin
            countdown_nxt = cd_dec;
            if (cd_dec == '0) begin
              countdown_nxt = reload_val;
              next_tick_nxt = !next_tick_r;
              if (next_tick_r) begin
                ev = EV_TICK;
              end else begin
                ev        = EV_TOCK;
                phase_nxt = '0;
              end
            end
          end
        end
        FN_START: begin
          if (!running_r) begin
            countdown_nxt = reload_val;
            next_tick_nxt = 1'b1;
            running_nxt   = 1'b1;
          end
        end
        FN_STOP:      running_nxt = 1'b0;
        FN_OFF_RESET: offset_nxt  = '0;
        FN_OFF_INC: begin
          if (offset_r != OFFSET_MAX) begin
            offset_nxt = offset_r + 16'sd1;
          end
        end
        FN_OFF_DEC: begin
          if (offset_r != OFFSET_MIN) begin
            offset_nxt = offset_r - 16'sd1;
          end
        end
        FN_SET_PHASE: phase_nxt = clamp_s[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign result.event_res  = ev;
  assign result.offset_now = offset_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      running_r   <= 1'b0;
      next_tick_r <= 1'b1;
      countdown_r <= '0;
      phase_r     <= '0;
      offset_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      running_r   <= running_nxt;
      next_tick_r <= next_tick_nxt;
      countdown_r <= countdown_nxt;
      phase_r     <= phase_nxt;
      offset_r    <= offset_nxt;
    end
  end

`ifndef SYNTHESIS
  a_reload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.func == FN_TIME) && running_r |=> countdown_r != '0)
    else $error("countdown left at zero while running");

  a_tock_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ev == EV_TOCK |=> phase_r == '0)
    else $error("phase shift not cleared after tock");

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.func == FN_START) && !running_r |=> running_r && next_tick_r)
    else $error("start did not arm the timer on tick");

  a_event_cause: assert property (@(posedge clk) disable iff (!rst_n)
    ev != EV_NONE |-> fire && (item.func == FN_TIME) && running_r)
    else $error("event fired without elapsed time while running");
`endif

endmodule

/* src/ttpa_out_stage.sv */
// Result register stage for event transactions.
module ttpa_out_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  ttpa_pkg::result_t                   result,
  output logic                                accept_ok,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ttpa_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import ttpa_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign accept_ok  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OFFSET_W-EVENT_W){1'b0}},
                       result_r.offset_now, result_r.event_res};

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

/* src/tick_tock_phase_adjust_timer_top.sv */
// Top level of the tick/tock phase adjust timer.
//
//   channel | ports                  | moves
//   --------+------------------------+------------------------------------
//   in      | in_tvalid/tready/tdata | command transaction, func in tuser
//   out     | out_tvalid/tready/tdata| event and current offset
//   cfg     | cfg_wr_en/wr_data      | period_us write, no handshake
//
// One transaction per cycle while out_tready keeps the output moving; each
// passes through the input register and then the result register.
// Reload, offset and phase clamp are one add-and-compare pass in the core.
// Reset clears the timer to stopped, tick next, zero offset and phase.
// A stalled output holds its result; the input register then fills and
// in_tready drops until the result is taken.
module tick_tock_phase_adjust_timer_top #(
  parameter int COUNT_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [20:0] phase_request
  input  logic [ttpa_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] func
  input  logic [ttpa_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] event_res, [17:2] offset_now
  output logic [ttpa_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [ttpa_pkg::PERIOD_W-1:0]      cfg_wr_data
);
  import ttpa_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    accept_ok;
  logic    take;
  result_t result;

  assign in_item.func          = in_tuser[FUNC_W-1:0];
  assign in_item.phase_request = $signed(in_tdata[PHASE_REQ_W-1:0]);
  assign take                  = item_valid && accept_ok;

  ttpa_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ttpa_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (take),
    .item        (item),
    .result      (result)
  );

  ttpa_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .result     (result),
    .accept_ok  (accept_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
